### rtl/core/gcth_pkg.sv
// ----------------------------------------------------------------------------
// gcth_pkg
// Shared types and constants of the gated coincidence time histogram.
// ----------------------------------------------------------------------------
`default_nettype none
package gcth_pkg;
    localparam int EW = 20;
    localparam int TW = 48;
    localparam int BW = 12;
    localparam int OW = 32;

    localparam logic [2:0] REG_GATE_LO  = 3'd0;
    localparam logic [2:0] REG_GATE_HI  = 3'd1;
    localparam logic [2:0] REG_GAMMA_LO = 3'd2;
    localparam logic [2:0] REG_GAMMA_HI = 3'd3;
    localparam logic [2:0] REG_THRESH   = 3'd4;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic store_hit;   // write input hit at hit count
        logic clr_hits;    // clear hit count
        logic load_i;      // pair walk: i = 0, j = 0
        logic step;        // pair walk: advance j, i
        logic pair_go;     // pair at (i,j) read issued this cycle
        logic rd_go;       // histogram read request
        logic clr_step;    // clearing pass step
        logic out_load;    // capture read data into output register
    } gcth_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;   // last pair issued
        logic clr_done;    // last bin cleared
        logic pipe_busy;   // update pipeline holds work
    } gcth_stat_t;
endpackage
`default_nettype wire

### rtl/core/gated_coincidence_time_histogram.sv
// ----------------------------------------------------------------------------
// gated_coincidence_time_histogram
// Gated gamma-gamma timing histogram with hit store and pair walk.
// ----------------------------------------------------------------------------
// channel  direction  contents
// s_*      in         hits and bin read requests
// m_*      out        bin counts
// cfg_*    in         window and threshold registers
// After reset a clearing pass over all NUM_BINS+2 bins runs before s_tready rises.
// A hit is stored as it is accepted; a bin read registers the histogram port
// output, then loads it into the output register. The last hit runs a pair
// walk over every (i,j) pair of hits, then drains the update pipeline. A count
// in the output register stalls every new transaction until m_tready takes it.
// ----------------------------------------------------------------------------
`default_nettype none
module gated_coincidence_time_histogram #(
    parameter int MAX_HITS    = 16,
    parameter int NUM_BINS    = 2048,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,  // cmd, hit_energy, hit_time, read_bin, zero fill
    input  wire logic        s_tlast,  // last_hit
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // bin_count, bin_echo, zero fill
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);
    import gcth_pkg::*;

    logic [15:0]   gate_lo_reg, gate_hi_reg, gamma_lo_reg, gamma_hi_reg;
    logic [EW-1:0] thr_reg;
    gcth_cmd_t     cmd;
    gcth_stat_t    stat;
    logic [OW-1:0] rd_count, cnt_reg;
    logic [BW-1:0] rd_bin, echo_reg;
    logic          mv_reg, rdy_core;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_lo_reg  <= '0;
            gate_hi_reg  <= '1;
            gamma_lo_reg <= '0;
            gamma_hi_reg <= '1;
            thr_reg      <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GATE_LO:  gate_lo_reg  <= cfg_data[15:0];
                REG_GATE_HI:  gate_hi_reg  <= cfg_data[15:0];
                REG_GAMMA_LO: gamma_lo_reg <= cfg_data[15:0];
                REG_GAMMA_HI: gamma_hi_reg <= cfg_data[15:0];
                REG_THRESH:   thr_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = rdy_core;

    gcth_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(rdy_core),
        .in_cmd(s_tdata[0]), .in_last(s_tlast),
        .out_busy(mv_reg), .out_take(m_tready),
        .cmd(cmd), .stat(stat)
    );

    gcth_dp #(.MAX_HITS(MAX_HITS), .NUM_BINS(NUM_BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_energy(s_tdata[20:1]), .in_time(s_tdata[68:21]), .in_bin(s_tdata[80:69]),
        .gate_lo(gate_lo_reg), .gate_hi(gate_hi_reg),
        .gamma_lo(gamma_lo_reg), .gamma_hi(gamma_hi_reg), .thresh(thr_reg),
        .cmd(cmd), .stat(stat), .rd_count(rd_count), .rd_bin(rd_bin)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= 1'b0;
        else if (cmd.out_load) mv_reg <= 1'b1;
        else if (m_tready) mv_reg <= 1'b0;
        if (cmd.out_load) begin
            cnt_reg  <= rd_count;
            echo_reg <= rd_bin;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {4'd0, echo_reg, cnt_reg};

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("count dropped");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !mv_reg || m_tready) else $error("count overwritten");
    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> !stat.pipe_busy) else $error("config while busy");
`endif
endmodule
`default_nettype wire

### rtl/core/gcth_ctrl.sv
// ----------------------------------------------------------------------------
// gcth_ctrl
// Controller: reset clearing pass, hit loading, pair walk and bin reads.
// ----------------------------------------------------------------------------
`default_nettype none
module gcth_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               in_cmd,
    input  wire logic               in_last,
    input  wire logic               out_busy,
    input  wire logic               out_take,
    output gcth_pkg::gcth_cmd_t     cmd,
    input  wire gcth_pkg::gcth_stat_t stat
);
    import gcth_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_WALK  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_READ  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   acc;

    assign in_ready = (state_reg == S_IDLE) && !(out_busy && !out_take);
    assign acc      = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (acc && in_cmd == CMD_READ) begin
                    cmd.rd_go  = 1'b1;
                    state_next = S_READ;
                end else if (acc) begin
                    cmd.store_hit = 1'b1;
                    if (in_last) begin
                        cmd.load_i = 1'b1;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                cmd.pair_go = 1'b1;
                cmd.step    = 1'b1;
                if (stat.walk_done) state_next = S_DRAIN;
            end
            S_DRAIN: begin
                if (!stat.pipe_busy) begin
                    cmd.clr_hits = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_READ: begin
                cmd.out_load = 1'b1;
                state_next   = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_CLEAR;
        else          state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_read_goes_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_READ |-> cmd.out_load) else $error("read lost");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !in_ready) else $error("accept while busy");
    a_walk_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DRAIN && !stat.pipe_busy |=> state_reg == S_IDLE)
        else $error("drain stuck");
`endif
endmodule
`default_nettype wire

### rtl/core/gcth_dp.sv
// ----------------------------------------------------------------------------
// gcth_dp
// Datapath: hit store, window checks, pair difference, binning and the
// histogram memory with a saturating read-modify-write pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module gcth_dp #(
    parameter int MAX_HITS    = 16,
    parameter int NUM_BINS    = 2048,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic [gcth_pkg::EW-1:0] in_energy,
    input  wire logic signed [gcth_pkg::TW-1:0] in_time,
    input  wire logic [gcth_pkg::BW-1:0] in_bin,
    input  wire logic [15:0]             gate_lo,
    input  wire logic [15:0]             gate_hi,
    input  wire logic [15:0]             gamma_lo,
    input  wire logic [15:0]             gamma_hi,
    input  wire logic [gcth_pkg::EW-1:0] thresh,
    input  wire gcth_pkg::gcth_cmd_t     cmd,
    output gcth_pkg::gcth_stat_t         stat,
    output logic [gcth_pkg::OW-1:0]      rd_count,
    output logic [gcth_pkg::BW-1:0]      rd_bin
);
    import gcth_pkg::*;

    localparam int HW    = $clog2(MAX_HITS);
    localparam int CW    = $clog2(MAX_HITS + 1);
    localparam int DEPTH = NUM_BINS + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = TW + 1;
    localparam logic signed [DW-1:0] HALF = DW'(NUM_BINS / 2 * 16);
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic [EW-1:0]        en_mem [MAX_HITS];
    logic signed [TW-1:0] tm_mem [MAX_HITS];
    logic [COUNT_WIDTH-1:0] hist [DEPTH];

    logic [CW-1:0] cnt_reg;
    logic [HW-1:0] i_reg, j_reg;
    logic [AW-1:0] clr_reg;

    // stage 1: pair operands
    logic                 p1_v_reg;
    logic signed [TW-1:0] t1_reg, t2_reg;
    // stage 2: difference
    logic                 p2_v_reg;
    logic signed [DW-1:0] d_reg;
    // stage 3: bin index, memory read
    logic                 p3_v_reg;
    logic [AW-1:0]        a3_reg;
    logic [COUNT_WIDTH-1:0] q_reg;
    // stage 4: write back
    logic                 p4_v_reg;
    logic [AW-1:0]        a4_reg;
    logic [COUNT_WIDTH-1:0] w4_reg;
    // write done at the previous edge
    logic                 p5_v_reg;
    logic [AW-1:0]        a5_reg;
    logic [COUNT_WIDTH-1:0] w5_reg;

    logic [HW-1:0] last_idx;
    logic          ok1, ok2;
    logic [EW-1:0] e1, e2;
    logic [AW-1:0] bin_c, rd_a;
    logic [COUNT_WIDTH-1:0] qv, inc;
    logic          rd_req_reg;
    logic [BW-1:0] rbin_reg;

    function automatic logic in_win(input logic [EW-1:0] e, input logic [15:0] a,
                                    input logic [15:0] b, input logic [EW-1:0] th);
        logic [15:0] lo, hi;
        lo = (a <= b) ? a : b;
        hi = (a <= b) ? b : a;
        return (e > th) && (e >= {lo, 4'd0}) && (e <= {hi, 4'd0});
    endfunction

    assign last_idx = HW'(cnt_reg - CW'(1));
    assign e1  = en_mem[i_reg];
    assign e2  = en_mem[j_reg];
    assign ok1 = in_win(e1, gate_lo, gate_hi, thresh);
    assign ok2 = in_win(e2, gamma_lo, gamma_hi, thresh);

    assign stat.walk_done = (i_reg == last_idx) && (j_reg == last_idx);
    assign stat.clr_done  = (clr_reg == AW'(DEPTH - 1));
    assign stat.pipe_busy = p1_v_reg | p2_v_reg | p3_v_reg | p4_v_reg;

    always_ff @(posedge aclk) begin
        if (cmd.store_hit && cnt_reg < CW'(MAX_HITS)) begin
            en_mem[cnt_reg[HW-1:0]] <= in_energy;
            tm_mem[cnt_reg[HW-1:0]] <= in_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            clr_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p5_v_reg <= 1'b0;
            rd_req_reg <= 1'b0;
        end else begin
            if (cmd.clr_hits) cnt_reg <= '0;
            else if (cmd.store_hit && cnt_reg < CW'(MAX_HITS)) cnt_reg <= cnt_reg + CW'(1);
            if (cmd.clr_step) clr_reg <= clr_reg + AW'(1);
            if (cmd.load_i) begin
                i_reg <= '0;
                j_reg <= '0;
            end else if (cmd.step) begin
                if (j_reg == last_idx) begin
                    j_reg <= '0;
                    i_reg <= i_reg + HW'(1);
                end else begin
                    j_reg <= j_reg + HW'(1);
                end
            end
            p1_v_reg <= cmd.pair_go && (i_reg != j_reg) && ok1 && ok2;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg && (qv != CMAX);
            p5_v_reg <= p4_v_reg;
            rd_req_reg <= cmd.rd_go;
        end
    end

    always_ff @(posedge aclk) begin
        t1_reg <= tm_mem[i_reg];
        t2_reg <= tm_mem[j_reg];
        d_reg  <= DW'(t1_reg) - DW'(t2_reg);
        rbin_reg <= in_bin;
    end

    // bin index; shift keeps floor for nonnegative offsets
    always_comb begin
        logic [DW-1:0] off;
        off = DW'(d_reg + HALF);
        if (d_reg < -HALF)      bin_c = '0;
        else if (d_reg >= HALF) bin_c = AW'(NUM_BINS + 1);
        else                    bin_c = AW'(off >> 4) + AW'(1);
    end

    // forward the write in flight and the one just done when the same bin is read again
    assign qv  = (p4_v_reg && a4_reg == a3_reg) ? w4_reg :
                 (p5_v_reg && a5_reg == a3_reg) ? w5_reg : q_reg;
    assign inc = qv + COUNT_WIDTH'(1);
    assign rd_a = cmd.rd_go ? AW'(in_bin) : bin_c;

    always_ff @(posedge aclk) begin
        q_reg  <= hist[rd_a];
        a3_reg <= bin_c;
        a4_reg <= a3_reg;
        w4_reg <= inc;
        a5_reg <= a4_reg;
        w5_reg <= w4_reg;
        if (cmd.clr_step)  hist[clr_reg] <= '0;
        else if (p4_v_reg) hist[a4_reg] <= w4_reg;
    end

    always_comb begin
        rd_bin = rbin_reg;
        if ({4'd0, rbin_reg} >= (AW + 4)'(DEPTH)) rd_count = '0;
        else if (COUNT_WIDTH > OW && q_reg > COUNT_WIDTH'({OW{1'b1}})) rd_count = '1;
        else rd_count = OW'(q_reg);
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_HITS)) else $error("hit count overflow");
    a_no_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pair_go && i_reg == j_reg |=> !p1_v_reg) else $error("self pair counted");
    a_read_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_req_reg |-> !p4_v_reg) else $error("read during update");
`endif
endmodule
`default_nettype wire

### tb/gcth_scoreboard.sv
// ----------------------------------------------------------------------------
// gcth_scoreboard
// Predicts bin counts of the gated coincidence time histogram and checks them.
// ----------------------------------------------------------------------------
`default_nettype none
package gcth_scoreboard_pkg;
    import gcth_pkg::*;

    localparam int HITS_MAX   = 16;
    localparam int BINS       = 2048;
    localparam int HIST_BINS  = BINS + 2;
    localparam longint HALF_TICKS = longint'(BINS / 2) * 16;

    typedef struct {
        logic [OW-1:0] count;
        logic [BW-1:0] echo;
    } bin_read_t;

    class gcth_scoreboard;
        logic [15:0]   gate_lo, gate_hi, gamma_lo, gamma_hi;
        logic [EW-1:0] thresh;
        logic [EW-1:0] hit_e[HITS_MAX];
        longint        hit_t[HITS_MAX];
        int            nhits;
        logic [OW-1:0] hist[HIST_BINS];
        bin_read_t     pending_reads[$];
        int            errors;

        function new();
            gate_lo  = 16'd0;
            gate_hi  = 16'hFFFF;
            gamma_lo = 16'd0;
            gamma_hi = 16'hFFFF;
            thresh   = '0;
            nhits    = 0;
            errors   = 0;
            foreach (hist[k]) hist[k] = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [19:0] val);
            case (idx)
                REG_GATE_LO:  gate_lo  = val[15:0];
                REG_GATE_HI:  gate_hi  = val[15:0];
                REG_GAMMA_LO: gamma_lo = val[15:0];
                REG_GAMMA_HI: gamma_hi = val[15:0];
                REG_THRESH:   thresh   = val;
                default: ;
            endcase
        endfunction

        // bounds are whole keV, energies 1/16 keV; reversed bounds are swapped
        function bit in_window(logic [EW-1:0] e, logic [15:0] a, logic [15:0] b);
            longint lo, hi;
            lo = (a <= b) ? a : b;
            hi = (a <= b) ? b : a;
            return (longint'(e) >= lo * 16) && (longint'(e) <= hi * 16);
        endfunction

        function void count_delta(longint d);
            int b;
            if (d < -HALF_TICKS)
                b = 0;
            else if (d >= HALF_TICKS)
                b = HIST_BINS - 1;
            else
                b = int'((d + HALF_TICKS) / 16) + 1;
            if (hist[b] != '1)
                hist[b] = hist[b] + 1;
        endfunction

        function void accumulate_pairs();
            for (int i = 0; i < nhits; i++) begin
                if (hit_e[i] <= thresh || !in_window(hit_e[i], gate_lo, gate_hi))
                    continue;
                for (int j = 0; j < nhits; j++) begin
                    if (j == i)
                        continue;
                    if (hit_e[j] <= thresh || !in_window(hit_e[j], gamma_lo, gamma_hi))
                        continue;
                    count_delta(hit_t[i] - hit_t[j]);
                end
            end
        endfunction

        function void note_input(logic cmd, logic [EW-1:0] e, logic signed [TW-1:0] t,
                                 logic last, logic [BW-1:0] req);
            bin_read_t r;
            if (cmd == CMD_READ) begin
                r.count = (req < HIST_BINS) ? hist[req] : '0;
                r.echo  = req;
                pending_reads.push_back(r);
                return;
            end
            if (nhits < HITS_MAX) begin
                hit_e[nhits] = e;
                hit_t[nhits] = longint'(t);
                nhits++;
            end
            if (last) begin
                accumulate_pairs();
                nhits = 0;
            end
        endfunction

        function void check_result(logic [OW-1:0] count, logic [BW-1:0] echo);
            bin_read_t r;
            if (pending_reads.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected count transaction: count %0d bin %0d", count, echo);
                return;
            end
            r = pending_reads.pop_front();
            if (r.count !== count || r.echo !== echo) begin
                errors++;
                if (errors <= 10)
                    $display("bin read: expected count %0d bin %0d, got count %0d bin %0d",
                             r.count, r.echo, count, echo);
            end
        endfunction
    endclass
endpackage
`default_nettype wire

### tb/gated_coincidence_time_histogram_tb.sv
// ----------------------------------------------------------------------------
// gated_coincidence_time_histogram_tb
// Streams hit events and bin reads through the histogram under several window
// and threshold settings, with random stalls on both sides, and compares each
// returned bin count against an in-bench model of the pair walk.
// ----------------------------------------------------------------------------
`default_nettype none
module gated_coincidence_time_histogram_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gcth_pkg::*;
    import gcth_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN       = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;

    gcth_scoreboard hist_model = new();
    bit  quiet = 1'b0;
    int  cycles = 0;

    gated_coincidence_time_histogram DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("gated_coincidence_time_histogram: mismatch");
            $finish;
        end
    end

    // result side: random stalls, then accept and check
    initial begin
        logic [OW-1:0] cnt;
        logic [BW-1:0] echo;
        @(posedge aclk iff aresetn);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk iff (m_tvalid && m_tready));
            cnt  = m_tdata[31:0];
            echo = m_tdata[43:32];
            hist_model.check_result(cnt, echo);
        end
    end

    task automatic send(logic cmd, logic [EW-1:0] e, logic [TW-1:0] t, logic last,
                        logic [BW-1:0] req);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tdata  <= {7'd0, req, t, e, cmd};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk iff (s_tvalid && s_tready));
        hist_model.note_input(cmd, e, t, last, req);
    endtask

    task automatic read_bin(logic [BW-1:0] req);
        send(CMD_READ, EW'($urandom), TW'({$urandom, $urandom} >> 16),
             1'($urandom_range(0, 1)), req);
    endtask

    // waits out the pair walk too, since an event close returns nothing
    task automatic settle();
        s_tvalid <= 1'b0;
        while (hist_model.pending_reads.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk iff (cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        hist_model.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic setup(logic [15:0] glo, logic [15:0] ghi, logic [15:0] mlo,
                         logic [15:0] mhi, logic [19:0] th);
        settle();
        write_reg(REG_GATE_LO, 20'(glo));
        write_reg(REG_GATE_HI, 20'(ghi));
        write_reg(REG_GAMMA_LO, 20'(mlo));
        write_reg(REG_GAMMA_HI, 20'(mhi));
        write_reg(REG_THRESH, th);
    endtask

    function automatic logic [EW-1:0] pick_energy();
        case ($urandom_range(0, 3))
            0: return EW'($urandom);
            1: return EW'($urandom_range(0, 3000 * 16));
            default: return EW'($urandom_range(0, 1200 * 16));
        endcase
    endfunction

    function automatic logic [BW-1:0] pick_bin();
        case ($urandom_range(0, 5))
            0: return BW'($urandom);
            1: return $urandom_range(0, 1) ? BW'(0) : BW'(BINS + 1);
            2: return BW'($urandom_range(0, BINS + 1));
            default: return BW'($urandom_range(BINS / 2 - 100, BINS / 2 + 100));
        endcase
    endfunction

    // one event of n hits with times clustered near a random base (fully random when wide), reads mixed in
    task automatic random_event(int n, bit wide, inout int sent);
        logic [TW-1:0] base, t;
        base = TW'({$urandom, $urandom});
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                read_bin(pick_bin());
                sent++;
            end
            t = wide ? TW'({$urandom, $urandom}) : base + TW'($urandom_range(0, 40000)) - 20000;
            send(CMD_ADD, pick_energy(), t, k == n - 1, BW'($urandom));
            sent++;
        end
    endtask

    initial begin
        logic [TW-1:0] tmax, tmin;
        int sent;
        sent = 0;
        tmax = {1'b0, {(TW-1){1'b1}}};
        tmin = {1'b1, {(TW-1){1'b0}}};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // empty histogram, edge and out-of-range bins
        read_bin(12'd0);
        read_bin(12'(BINS + 1));
        read_bin(12'(BINS + 2));
        read_bin(12'hFFF);
        // extreme energies and times, with a read in the middle of the event
        send(CMD_ADD, '1, tmax, 1'b0, '1);
        send(CMD_ADD, '0, tmin, 1'b0, '0);
        read_bin(12'd1);
        send(CMD_ADD, EW'(1000 * 16), '0, 1'b0, '0);
        send(CMD_ADD, EW'(2000 * 16), TW'(160), 1'b1, '0);
        read_bin(12'd0);
        read_bin(12'(BINS + 1));
        read_bin(12'(BINS / 2 + 1));
        read_bin(12'(BINS / 2 - 9));
        // more hits than the store holds, closed by a dropped hit
        for (int k = 0; k < 18; k++)
            send(CMD_ADD, EW'(500 * 16 + k), TW'(k * 37), k == 17, '0);
        read_bin(12'(BINS / 2 + 1));
        read_bin(12'(BINS / 2));
        sent = 23;

        // phases: defaults, narrow windows with reversed gamma, then the extremes
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: setup(16'd100, 16'd900, 16'd2000, 16'd50, 20'(300 * 16));
                2: setup(16'hFFFF, 16'd0, 16'd0, 16'd0, 20'd0);
                3: setup(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 20'hFFFFF);
                4: setup(16'd200, 16'd200, 16'd0, 16'hFFFF, 20'd1);
                default: ;
            endcase
            while (sent < 23 + (ph + 1) * 115) begin
                if (ph == 4 && sent > 500)
                    quiet = 1'b1;
                case ($urandom_range(0, 9))
                    0: read_bin(pick_bin());
                    1: begin
                        send(CMD_ADD, EW'($urandom), TW'({$urandom, $urandom}),
                             1'($urandom_range(0, 1)), BW'($urandom));
                        sent++;
                    end
                    2: random_event($urandom_range(14, 20), 1'b0, sent);
                    3: random_event($urandom_range(1, 6), 1'b1, sent);
                    default: random_event($urandom_range(2, 8), 1'b0, sent);
                endcase
                sent++;
                if (ph == 2 && sent > 300 && sent < 310)
                    settle();
            end
            for (int k = 0; k < 12; k++)
                read_bin(BW'($urandom_range(BINS / 2 - 20, BINS / 2 + 20)));
        end

        s_tvalid <= 1'b0;
        while (hist_model.pending_reads.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (hist_model.errors == 0 && hist_model.pending_reads.size() == 0) begin
            $display("gated_coincidence_time_histogram: match");
        end else begin
            $display("gated_coincidence_time_histogram: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

### gated_coincidence_time_histogram.f
rtl/core/gcth_pkg.sv
rtl/core/gcth_ctrl.sv
rtl/core/gcth_dp.sv
rtl/core/gated_coincidence_time_histogram.sv
tb/gcth_scoreboard.sv
tb/gated_coincidence_time_histogram_tb.sv
